[hw/rtl/lcg48_pkg.sv]
// shared types and constants of the 48-bit lcg random generator
package lcg48_pkg;

	localparam logic [47:0] LCG_MULT = 48'h0005_DEEC_E66D;
	localparam logic [47:0] LCG_ADD  = 48'h0000_0000_000B;
	// multiplier split at bit 24 for the shared 24x24 product
	localparam logic [23:0] MULT_LO  = LCG_MULT[23:0];
	localparam logic [23:0] MULT_HI  = LCG_MULT[47:24];

	typedef enum logic [2:0] {
		OP_RESEED    = 3'd0,
		OP_NEXT_BITS = 3'd1,
		OP_NEXT_INT  = 3'd2,
		OP_NEXT_LONG = 3'd3,
		OP_UNIFORM   = 3'd4,
		OP_INT_RANGE = 3'd5
	} lcg48_op_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic adv_first;
		logic adv_mid;
		logic adv_last;
		logic draw_second;
		logic div_start;
		logic out_load;
	} lcg48_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       span_zero;
		logic       div_busy;
	} lcg48_status_t;

endpackage

[hw/rtl/lcg48_if.sv]
// request and response channel interfaces of the lcg generator
interface lcg48_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [5:0]  bit_count;
	logic [47:0] seed_value;
	logic [63:0] range_min;
	logic [63:0] range_max;

	modport source (
		output valid, opcode, bit_count, seed_value, range_min, range_max,
		input  ready
	);
	modport sink (
		input  valid, opcode, bit_count, seed_value, range_min, range_max,
		output ready
	);
endinterface

interface lcg48_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;

	modport source (output valid, value, input ready);
	modport sink (input valid, value, output ready);
endinterface

[hw/rtl/lcg48_div.sv]
// bit-serial unsigned 64-bit remainder unit
module lcg48_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic [63:0] remainder
);

	localparam int W  = 64;
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q, dvd_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			// restoring step: keep the difference when it did not go negative
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
			end else begin
				rem_q <= trial[W-1:0];
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule

[hw/rtl/lcg48_datapath.sv]
// generator state, shared multiplier, draw registers and result formatting
module lcg48_datapath import lcg48_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  lcg48_cmd_t    cmd,
	output lcg48_status_t status,
	input  logic [2:0]    opcode,
	input  logic [5:0]    bit_count,
	input  logic [47:0]   seed_value,
	input  logic [63:0]   range_min,
	input  logic [63:0]   range_max,
	output logic [63:0]   value
);

	logic [47:0] state_q;
	logic [47:0] acc_q;
	logic [2:0]  op_q;
	logic [5:0]  bit_count_q;
	logic [63:0] min_q;
	logic [63:0] max_q;
	logic [31:0] draw_a_q;
	logic [31:0] draw_b_q;
	logic [63:0] value_q;

	logic [23:0] mul_a;
	logic [23:0] mul_b;
	logic [47:0] product;
	logic [47:0] acc_next;
	logic [63:0] span;
	logic [63:0] sext_a;
	logic [5:0]  n_bits;
	logic [5:0]  shift;
	logic [31:0] top_bits;
	logic        div_busy;
	logic [63:0] rem;
	logic [63:0] result;

	// one 24x24 product per step, high x high term falls outside 48 bits
	assign mul_a   = cmd.adv_mid ? state_q[47:24] : state_q[23:0];
	assign mul_b   = cmd.adv_last ? MULT_HI : MULT_LO;
	assign product = mul_a * mul_b;

	always_comb begin
		if (cmd.adv_first) begin
			acc_next = product + LCG_ADD;
		end else begin
			acc_next = acc_q + {product[23:0], 24'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cmd.load && opcode == OP_RESEED) begin
			state_q <= seed_value ^ LCG_MULT;
		end else if (cmd.adv_last) begin
			state_q <= acc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= opcode;
			bit_count_q <= bit_count;
			min_q       <= range_min;
			max_q       <= range_max;
		end
		if (cmd.adv_first || cmd.adv_mid) begin
			acc_q <= acc_next;
		end
		if (cmd.adv_last) begin
			if (cmd.draw_second) begin
				draw_b_q <= acc_next[47:16];
			end else begin
				draw_a_q <= acc_next[47:16];
			end
		end
		if (cmd.out_load) begin
			value_q <= result;
		end
	end

	assign span   = max_q - min_q + 64'd1;
	assign sext_a = {{32{draw_a_q[31]}}, draw_a_q};

	lcg48_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (sext_a),
		.divisor   (span),
		.busy      (div_busy),
		.remainder (rem)
	);

	// counts above 32 saturate, a zero count yields zero
	assign n_bits   = (bit_count_q > 6'd32) ? 6'd32 : bit_count_q;
	assign shift    = 6'd32 - n_bits;
	assign top_bits = (n_bits == 6'd0) ? 32'd0 : (draw_a_q >> shift);

	always_comb begin
		case (op_q)
			OP_NEXT_BITS: result = {{32{top_bits[31]}}, top_bits};
			OP_NEXT_INT:  result = sext_a;
			OP_NEXT_LONG: result = {draw_a_q, draw_b_q};
			OP_UNIFORM:   result = {11'd0, draw_a_q[31:6], draw_b_q[31:5]};
			OP_INT_RANGE: result = min_q + (status.span_zero ? sext_a : rem);
			default:      result = 64'd0;
		endcase
	end

	assign status.op        = op_q;
	assign status.span_zero = (span == 64'd0);
	assign status.div_busy  = div_busy;
	assign value            = value_q;

endmodule

[hw/rtl/lcg48_ctrl.sv]
// sequencing state machine of the lcg generator
module lcg48_ctrl import lcg48_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  lcg48_status_t status,
	output lcg48_cmd_t    cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DISPATCH = 8'b0000_0010,
		S_ADV0     = 8'b0000_0100,
		S_ADV1     = 8'b0000_1000,
		S_ADV2     = 8'b0001_0000,
		S_SPAN     = 8'b0010_0000,
		S_DIV      = 8'b0100_0000,
		S_RESULT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   second_q;
	logic   out_valid_q;
	logic   two_draws;
	logic   draws_any;

	assign two_draws = (status.op == OP_NEXT_LONG) || (status.op == OP_UNIFORM);
	assign draws_any = (status.op == OP_NEXT_BITS) || (status.op == OP_NEXT_INT) ||
	                   two_draws || (status.op == OP_INT_RANGE);

	always_comb begin
		state_next      = state_q;
		cmd             = '0;
		cmd.draw_second = second_q;
		in_ready        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_next = draws_any ? S_ADV0 : S_RESULT;
			end
			S_ADV0: begin
				cmd.adv_first = 1'b1;
				state_next    = S_ADV1;
			end
			S_ADV1: begin
				cmd.adv_mid = 1'b1;
				state_next  = S_ADV2;
			end
			S_ADV2: begin
				cmd.adv_last = 1'b1;
				if (two_draws && !second_q) begin
					state_next = S_ADV0;
				end else if (status.op == OP_INT_RANGE) begin
					state_next = S_SPAN;
				end else begin
					state_next = S_RESULT;
				end
			end
			S_SPAN: begin
				if (status.span_zero) begin
					state_next = S_RESULT;
				end else begin
					cmd.div_start = 1'b1;
					state_next    = S_DIV;
				end
			end
			S_DIV: begin
				if (!status.div_busy) begin
					state_next = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				second_q <= 1'b0;
			end else if (cmd.adv_last && two_draws && !second_q) begin
				second_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/lcg48_random_generator_unit.sv]
// top level of the 48-bit lcg random generator
// One request transaction in, one response transaction out. The generator keeps a
// 48-bit state, reset to zero, advanced as state = state * 0x5DEECE66D + 0xB mod 2^48.
// Each advance steps through S_ADV0, S_ADV1 and S_ADV2 on one shared 24x24 multiplier.
// Reseed and unknown opcodes run no advance, next bits and next int run one, next
// long and uniform two, and int range one followed by the bit-serial 64-bit
// remainder loop (one bit per cycle); a zero span skips that loop. req.ready rises
// again in the cycle after the result is loaded, so a new request goes in while
// the previous response still waits in the output register.
module lcg48_random_generator_unit import lcg48_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lcg48_req_if.sink   req,
	lcg48_rsp_if.source rsp
);

	lcg48_cmd_t    cmd;
	lcg48_status_t status;

	// sequencing: handshakes and step commands
	lcg48_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// state, multiplier, remainder unit and output register
	lcg48_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.opcode     (req.opcode),
		.bit_count  (req.bit_count),
		.seed_value (req.seed_value),
		.range_min  (req.range_min),
		.range_max  (req.range_max),
		.value      (rsp.value)
	);

	// a pending response is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp.valid || rsp.ready))
		else $error("response register loaded while a response is pending");

	// the last advance step always follows the middle one
	a_adv_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv_last |-> $past(cmd.adv_mid))
		else $error("advance steps out of order");

	// starting the remainder loop makes it busy on the next cycle
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> status.div_busy)
		else $error("remainder unit did not start");

	// no new transaction is taken while the remainder loop runs
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !status.div_busy)
		else $error("request accepted while remainder unit busy");

endmodule
